FILE: hw/rtl/sdes_pkg.sv
// Shared types and constants for the servo drive enable sequencer.
// Holds control word codes, register indexes, stream packing offsets and limits.
// No dependencies.
package sdes_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_CMD_GAIN   = 2'd0;
	localparam logic [1:0] REG_FB_GAIN    = 2'd1;
	localparam logic [1:0] REG_RPM_GAIN   = 2'd2;
	localparam logic [1:0] REG_FAULT_GRACE = 2'd3;

	localparam int GAIN_W  = 48;
	localparam int GRACE_W = 31;
	localparam int CFG_W   = 48;
	localparam logic [GRACE_W-1:0] GRACE_RESET = 31'd100000000;

	// Control word codes.
	localparam logic [7:0] CW_NONE        = 8'h00;
	localparam logic [7:0] CW_SHUTDOWN    = 8'h06;
	localparam logic [7:0] CW_SWITCH_ON   = 8'h07;
	localparam logic [7:0] CW_ENABLE_OP   = 8'h0f;
	localparam logic [7:0] CW_FAULT_RESET = 8'h80;

	// Status flag positions.
	localparam int FLAG_READY    = 0;
	localparam int FLAG_SWON     = 1;
	localparam int FLAG_OPER     = 2;
	localparam int FLAG_FAULT    = 3;
	localparam int FLAG_DISABLED = 4;
	localparam logic [6:0] FLAGS_FAULT_ONLY = 7'h08;

	// Saturation limits.
	localparam logic [30:0] CMD_LIMIT = 31'h7fffffff;
	localparam logic [46:0] FB_LIMIT  = 47'h7fffffffffff;

	// Input stream packing (tdata), lowest field first.
	localparam int IN_W        = 128;
	localparam int IN_STATUS_LO = 0;
	localparam int IN_VEL_LO   = 16;
	localparam int IN_PERIOD_LO = 48;
	localparam int IN_ENABLE   = 78;
	localparam int IN_CMD_LO   = 79;

	// Output stream packing (tdata).
	localparam int OUT_W = 192;

	// Per-item control outcome from the state sequencer.
	typedef struct packed {
		logic [6:0] flags;
		logic       enabled;
		logic       fault;
		logic [7:0] ctrl_word;
	} ctrl_result_t;

endpackage

FILE: hw/rtl/sdes_state_ctrl.sv
// Status decode, fault grace timer and control word generation.
// Holds the fault timer, fault hold and last velocity state. Depends on sdes_pkg.
module sdes_state_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          link_operational,
	input  logic [15:0]                   status_word,
	input  logic [31:0]                   vel_raw,
	input  logic [29:0]                   period_ns,
	input  logic                          enable,
	input  logic [sdes_pkg::GRACE_W-1:0]  fault_grace_ns,
	output sdes_pkg::ctrl_result_t        result,
	output logic [31:0]                   vel_sel
);

	logic signed [31:0] fault_timer_q;
	logic               fault_hold_q;
	logic [31:0]        last_velocity_q;

	logic [6:0]         flags;
	logic               fault_now;
	logic               timer_expired;
	logic signed [31:0] timer_next;

	assign timer_expired = (fault_timer_q <= 32'sd0);

	always_comb begin
		if (link_operational) begin
			flags = {status_word[11], status_word[7], status_word[6], status_word[3],
				status_word[2], status_word[1], status_word[0]};
		end else begin
			flags = sdes_pkg::FLAGS_FAULT_ONLY;
		end
	end

	always_comb begin
		timer_next = fault_timer_q;
		fault_now  = fault_hold_q;
		if (link_operational) begin
			fault_now = 1'b0;
			if (enable && flags[sdes_pkg::FLAG_FAULT]) begin
				if (timer_expired) begin
					fault_now = 1'b1;
				end else begin
					timer_next = fault_timer_q - $signed({2'b00, period_ns});
				end
			end else begin
				timer_next = $signed({1'b0, fault_grace_ns});
			end
		end
	end

	always_comb begin
		result.ctrl_word = sdes_pkg::CW_NONE;
		if (enable) begin
			if (flags[sdes_pkg::FLAG_FAULT]) begin
				result.ctrl_word = sdes_pkg::CW_FAULT_RESET;
			end else if (flags[sdes_pkg::FLAG_DISABLED]) begin
				result.ctrl_word = sdes_pkg::CW_SHUTDOWN;
			end else if (flags[sdes_pkg::FLAG_READY]) begin
				result.ctrl_word = flags[sdes_pkg::FLAG_SWON] ? sdes_pkg::CW_ENABLE_OP
					: sdes_pkg::CW_SWITCH_ON;
			end
		end
		result.flags   = flags;
		result.enabled = flags[sdes_pkg::FLAG_READY] & flags[sdes_pkg::FLAG_SWON]
			& flags[sdes_pkg::FLAG_OPER];
		result.fault   = fault_now;
	end

	// Feedback is computed from the newest velocity seen while the link was up.
	assign vel_sel = link_operational ? vel_raw : last_velocity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_timer_q   <= '0;
			fault_hold_q    <= 1'b0;
			last_velocity_q <= '0;
		end else if (accept) begin
			fault_timer_q   <= timer_next;
			fault_hold_q    <= fault_now;
			last_velocity_q <= vel_sel;
		end
	end

endmodule

FILE: hw/rtl/servo_drive_enable_sequencer_unit.sv
// Servo drive enable sequencer top level: stream ports, configuration registers
// and the pipelined velocity scaling datapath. Depends on sdes_pkg and sdes_state_ctrl.
//
// Throughput: one request per cycle while the result stream is not stalled; the
// four-stage pipeline runs input, partial products, product sums, saturation and output.
// Reset: arst_n clears all pipeline valids, the drive state and the gains; the
// fault grace time resets to 100 ms. The block takes requests right after reset.
module servo_drive_enable_sequencer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_addr,
	input  logic [sdes_pkg::CFG_W-1:0]    cfg_wdata,
	// Request stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// status_word[15:0], vel_raw[47:16], period_ns[77:48], enable[78],
	// vel_command[126:79], zero fill[127]
	input  logic [sdes_pkg::IN_W-1:0]     s_tdata,
	// link_operational[0]
	input  logic [0:0]                    s_tuser,
	// Result stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status_flags[6:0], drive_enabled[7], fault_out[8], control_word[16:9],
	// vel_cmd_raw[48:17], vel_feedback[96:49], vel_rpm[144:97], vel_rpm_abs[191:145]
	output logic [sdes_pkg::OUT_W-1:0]    m_tdata
);

	// ------------------------------------------------------------------
	// Configuration registers. The command and feedback gains are kept as
	// magnitude and sign so the multipliers only ever see unsigned operands.
	// ------------------------------------------------------------------
	logic [47:0] cmd_gain_mag_q;
	logic        cmd_gain_neg_q;
	logic [47:0] fb_gain_mag_q;
	logic        fb_gain_neg_q;
	logic [47:0] rpm_gain_q;
	logic [sdes_pkg::GRACE_W-1:0] fault_grace_q;

	logic [47:0] cfg_mag;
	assign cfg_mag = cfg_wdata[47] ? (48'd0 - cfg_wdata) : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_gain_mag_q <= '0;
			cmd_gain_neg_q <= 1'b0;
			fb_gain_mag_q  <= '0;
			fb_gain_neg_q  <= 1'b0;
			rpm_gain_q     <= '0;
			fault_grace_q  <= sdes_pkg::GRACE_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				sdes_pkg::REG_CMD_GAIN: begin
					cmd_gain_mag_q <= cfg_mag;
					cmd_gain_neg_q <= cfg_wdata[47];
				end
				sdes_pkg::REG_FB_GAIN: begin
					fb_gain_mag_q <= cfg_mag;
					fb_gain_neg_q <= cfg_wdata[47];
				end
				sdes_pkg::REG_RPM_GAIN: begin
					rpm_gain_q <= cfg_wdata;
				end
				sdes_pkg::REG_FAULT_GRACE: begin
					fault_grace_q <= cfg_wdata[sdes_pkg::GRACE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. Each stage takes new data when it is empty or
	// when the stage after it moves, so bubbles collapse and the input keeps
	// flowing while a finished result waits at the output, until every stage is full.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;
	logic accept;

	assign rdy_out  = !m_tvalid || m_tready;
	assign rdy_s3   = !valid_s3 || rdy_out;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= accept;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_out) m_tvalid <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// Request fields and drive state sequencing. The state advances on the
	// accepting edge, so the control outcome is known when stage 1 loads.
	// ------------------------------------------------------------------
	logic [15:0] status_word;
	logic [31:0] vel_raw;
	logic [29:0] period_ns;
	logic        enable;
	logic [47:0] vel_command;
	logic [31:0] vel_sel;
	sdes_pkg::ctrl_result_t ctrl_res;

	assign status_word = s_tdata[sdes_pkg::IN_STATUS_LO +: 16];
	assign vel_raw     = s_tdata[sdes_pkg::IN_VEL_LO +: 32];
	assign period_ns   = s_tdata[sdes_pkg::IN_PERIOD_LO +: 30];
	assign enable      = s_tdata[sdes_pkg::IN_ENABLE];
	assign vel_command = s_tdata[sdes_pkg::IN_CMD_LO +: 48];

	sdes_state_ctrl u_state_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.link_operational (s_tuser[0]),
		.status_word      (status_word),
		.vel_raw          (vel_raw),
		.period_ns        (period_ns),
		.enable           (enable),
		.fault_grace_ns   (fault_grace_q),
		.result           (ctrl_res),
		.vel_sel          (vel_sel)
	);

	// Stage 1: control outcome and operand magnitudes.
	sdes_pkg::ctrl_result_t ctrl_s1;
	logic [47:0] cmd_mag_s1;
	logic        cmd_neg_s1;
	logic [31:0] vel_mag_s1;
	logic        vel_neg_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ctrl_s1    <= ctrl_res;
			cmd_mag_s1 <= vel_command[47] ? (48'd0 - vel_command) : vel_command;
			cmd_neg_s1 <= vel_command[47];
			vel_mag_s1 <= vel_sel[31] ? (32'd0 - vel_sel) : vel_sel;
			vel_neg_s1 <= vel_sel[31];
		end
	end

	// Stage 2: partial products, each at most 32 by 24 bits.
	sdes_pkg::ctrl_result_t ctrl_s2;
	logic [47:0] cmd_pp_ll_s2, cmd_pp_lh_s2, cmd_pp_hl_s2, cmd_pp_hh_s2;
	logic [55:0] fb_pp_lo_s2, fb_pp_hi_s2;
	logic [55:0] rpm_pp_lo_s2, rpm_pp_hi_s2;
	logic        cmd_neg_s2, fb_neg_s2, rpm_neg_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			ctrl_s2      <= ctrl_s1;
			cmd_pp_ll_s2 <= 48'(cmd_mag_s1[23:0])  * 48'(cmd_gain_mag_q[23:0]);
			cmd_pp_lh_s2 <= 48'(cmd_mag_s1[23:0])  * 48'(cmd_gain_mag_q[47:24]);
			cmd_pp_hl_s2 <= 48'(cmd_mag_s1[47:24]) * 48'(cmd_gain_mag_q[23:0]);
			cmd_pp_hh_s2 <= 48'(cmd_mag_s1[47:24]) * 48'(cmd_gain_mag_q[47:24]);
			fb_pp_lo_s2  <= 56'(vel_mag_s1) * 56'(fb_gain_mag_q[23:0]);
			fb_pp_hi_s2  <= 56'(vel_mag_s1) * 56'(fb_gain_mag_q[47:24]);
			rpm_pp_lo_s2 <= 56'(vel_mag_s1) * 56'(rpm_gain_q[23:0]);
			rpm_pp_hi_s2 <= 56'(vel_mag_s1) * 56'(rpm_gain_q[47:24]);
			cmd_neg_s2   <= cmd_neg_s1 ^ cmd_gain_neg_q;
			fb_neg_s2    <= vel_neg_s1 ^ fb_gain_neg_q;
			rpm_neg_s2   <= vel_neg_s1;
		end
	end

	// Stage 3: full product magnitudes.
	sdes_pkg::ctrl_result_t ctrl_s3;
	logic [95:0] cmd_prod_s3;
	logic [79:0] fb_prod_s3, rpm_prod_s3;
	logic        cmd_neg_s3, fb_neg_s3, rpm_neg_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			ctrl_s3     <= ctrl_s2;
			cmd_prod_s3 <= (96'(cmd_pp_hh_s2) << 48) + (96'(cmd_pp_lh_s2) << 24)
				+ (96'(cmd_pp_hl_s2) << 24) + 96'(cmd_pp_ll_s2);
			fb_prod_s3  <= (80'(fb_pp_hi_s2) << 24) + 80'(fb_pp_lo_s2);
			rpm_prod_s3 <= (80'(rpm_pp_hi_s2) << 24) + 80'(rpm_pp_lo_s2);
			cmd_neg_s3  <= cmd_neg_s2;
			fb_neg_s3   <= fb_neg_s2;
			rpm_neg_s3  <= rpm_neg_s2;
		end
	end

	// Output stage: shift out the fraction, saturate the magnitude, restore sign.
	// Truncation works on the magnitude, so every result rounds toward zero.
	logic [30:0] cmd_mag;
	logic [46:0] fb_mag, rpm_mag;
	logic [31:0] vel_cmd_raw;
	logic [47:0] vel_feedback, vel_rpm;

	always_comb begin
		cmd_mag = (cmd_prod_s3[95:63] != '0) ? sdes_pkg::CMD_LIMIT : cmd_prod_s3[62:32];
		fb_mag  = (fb_prod_s3[79:71] != '0) ? sdes_pkg::FB_LIMIT : fb_prod_s3[70:24];
		rpm_mag = (rpm_prod_s3[79:71] != '0) ? sdes_pkg::FB_LIMIT : rpm_prod_s3[70:24];
		vel_cmd_raw  = cmd_neg_s3 ? (32'd0 - {1'b0, cmd_mag}) : {1'b0, cmd_mag};
		vel_feedback = fb_neg_s3 ? (48'd0 - {1'b0, fb_mag}) : {1'b0, fb_mag};
		vel_rpm      = rpm_neg_s3 ? (48'd0 - {1'b0, rpm_mag}) : {1'b0, rpm_mag};
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			m_tdata <= {rpm_mag, vel_rpm, vel_feedback, vel_cmd_raw,
				ctrl_s3.ctrl_word, ctrl_s3.fault, ctrl_s3.enabled, ctrl_s3.flags};
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// A reported fault always comes with the fault status flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tdata[sdes_pkg::FLAG_FAULT])
		else $error("fault_out without fault status flag");

	// Drive enabled means ready, switched on and operation are all set.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> (m_tdata[2:0] == 3'b111))
		else $error("drive_enabled without all three state flags");

	// An accepted request always lands in the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted request lost at stage 1");

	// A full pipeline behind a stalled output must not take new requests.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && valid_s3 && valid_s2 && valid_s1 |-> !s_tready)
		else $error("request accepted into a full, stalled pipeline");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for servo_drive_enable_sequencer_unit: drive state decoding,
// fault grace timing, control word and velocity scaling, checked against a local predictor.
// Depends on sdes_pkg and the RTL of the unit only.
`timescale 1ns / 100ps

module tb_top;

	// Result stream field offsets, lowest field first, as packed by the unit.
	localparam int OUT_FLAGS_LO = 0;
	localparam int OUT_ENABLED  = 7;
	localparam int OUT_FAULT    = 8;
	localparam int OUT_CTRL_LO  = 9;
	localparam int OUT_CMD_LO   = 17;
	localparam int OUT_FB_LO    = 49;
	localparam int OUT_RPM_LO   = 97;
	localparam int OUT_ABS_LO   = 145;

	localparam int LATENCY       = 3;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 60;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_ITEMS   = 125;
	localparam int IDLE_PERCENT  = 13;
	localparam int NOISE_PERCENT = 12;

	localparam logic [29:0] PERIOD_MAX = 30'd1000000000;

	// Status words a well-behaved drive reports on its way to operation enabled or in fault, and bit masks.
	localparam logic [15:0] SW_DISABLED     = 16'h0040;
	localparam logic [15:0] SW_READY        = 16'h0021;
	localparam logic [15:0] SW_SWITCHED_ON  = 16'h0023;
	localparam logic [15:0] SW_OPERATION    = 16'h0027;
	localparam logic [15:0] SW_FAULT        = 16'h0008;
	localparam logic [15:0] SW_FAULT_ACTIVE = 16'h000f;
	localparam logic [15:0] SW_USED_BITS    = 16'h08cf;
	localparam logic [15:0] SW_WARN_LIMIT   = 16'h0880;

	typedef enum logic [1:0] {
		DRV_DISABLED,
		DRV_READY,
		DRV_SWITCHED_ON,
		DRV_OPERATION
	} drive_phase_t;

	typedef struct {
		logic        link;
		logic [15:0] status;
		logic [31:0] vel_raw;
		logic [29:0] period;
		logic        enable;
		logic [47:0] vel_cmd;
	} drive_req_t;

	typedef struct {
		logic [6:0]  flags;
		logic        enabled;
		logic        fault;
		logic [7:0]  ctrl;
		logic [31:0] cmd_raw;
		logic [47:0] feedback;
		logic [47:0] rpm;
		logic [46:0] rpm_abs;
	} drive_res_t;

	// One row of the directed stimulus. Where pinned is set, the control fields
	// of the result are typed in here instead of taken from the predictor.
	typedef struct {
		logic        link;
		logic [15:0] status;
		logic [31:0] vel_raw;
		logic [29:0] period;
		logic        enable;
		logic [47:0] vel_cmd;
		bit          pinned;
		logic [6:0]  flags;
		logic        enabled;
		logic        fault;
		logic [7:0]  ctrl;
	} directed_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [1:0]                     cfg_addr = '0;
	logic [sdes_pkg::CFG_W-1:0]     cfg_wdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [sdes_pkg::IN_W-1:0]      s_tdata = '0;
	logic [0:0]                     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [sdes_pkg::OUT_W-1:0]     m_tdata;

	// Local copy of the unit's registers and drive state, advanced per request.
	logic [47:0]          scale_cmd;
	logic [47:0]          scale_fb;
	logic [47:0]          scale_rpm;
	logic [30:0]          grace_ns;
	logic signed [31:0]   timer_ns;
	logic                 fault_latched;
	logic [31:0]          held_vel;

	drive_res_t           expected_results[$];
	int unsigned          mismatches = 0;

	// Idle control shared by both sides, and the long receiver hold-off request.
	bit                   idle_on = 1'b1;
	int unsigned          holds_asked = 0;
	int unsigned          holds_served = 0;
	int unsigned          hold_left = 0;

	// State of the random drive model that shapes well-formed sequences.
	drive_phase_t         drv_phase = DRV_DISABLED;
	int unsigned          fault_left = 0;

	directed_row_t        directed_rows [21];

	servo_drive_enable_sequencer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the unit hangs; the slowest correct run needs a small
	// fraction of this.
	initial begin
		#1000000;
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= 50) begin
			$display("%0t: %s got %h, expected %h", $time, field, got, want);
		end
	endtask

	function automatic logic [47:0] magnitude48(logic [47:0] x);
		return x[47] ? -x : x;
	endfunction

	// Drops the fraction bits of an unsigned product and clamps to the limit.
	function automatic logic [47:0] shift_saturate(logic [95:0] product, int unsigned sh,
			logic [47:0] lim);
		logic [95:0] q;
		q = product >> sh;
		return (q > {48'd0, lim}) ? lim : q[47:0];
	endfunction

	// Works out the result for one accepted request and advances the fault
	// timer, the latched fault and the held velocity exactly as the unit must.
	function automatic drive_res_t predict_drive_step(drive_req_t rq);
		drive_res_t  res;
		logic [47:0] mag_cmd;
		logic [47:0] mag_vel;
		logic [47:0] m;
		logic [47:0] r;
		logic        ready;
		logic        switched_on;
		logic        faulted;
		logic        disabled;

		res.enabled = 1'b0;
		if (rq.link) begin
			res.flags = {rq.status[11], rq.status[7], rq.status[6], rq.status[3],
				rq.status[2], rq.status[1], rq.status[0]};
			res.enabled = &res.flags[sdes_pkg::FLAG_OPER:sdes_pkg::FLAG_READY];
			fault_latched = 1'b0;
			if (rq.enable && res.flags[sdes_pkg::FLAG_FAULT]) begin
				// The timer only counts down while it is still positive; once it
				// has run out the fault is reported for every request in which it persists.
				if (timer_ns > 0) begin
					timer_ns = timer_ns - $signed({2'b00, rq.period});
				end else begin
					fault_latched = 1'b1;
				end
			end else begin
				timer_ns = $signed({1'b0, grace_ns});
			end
			held_vel = rq.vel_raw;
		end else begin
			// Link down: report only a fault, keep the timer and the last fault.
			res.flags = sdes_pkg::FLAGS_FAULT_ONLY;
		end
		res.fault = fault_latched;

		ready       = res.flags[sdes_pkg::FLAG_READY];
		switched_on = res.flags[sdes_pkg::FLAG_SWON];
		faulted     = res.flags[sdes_pkg::FLAG_FAULT];
		disabled    = res.flags[sdes_pkg::FLAG_DISABLED];
		res.ctrl = sdes_pkg::CW_NONE;
		if (rq.enable) begin
			if (faulted) begin
				res.ctrl = sdes_pkg::CW_FAULT_RESET;
			end else if (disabled) begin
				res.ctrl = sdes_pkg::CW_SHUTDOWN;
			end else if (ready) begin
				res.ctrl = switched_on ? sdes_pkg::CW_ENABLE_OP : sdes_pkg::CW_SWITCH_ON;
			end
		end

		// Sign and magnitude arithmetic: truncation is toward zero.
		mag_cmd = magnitude48(rq.vel_cmd);
		m = shift_saturate({48'd0, mag_cmd} * {48'd0, magnitude48(scale_cmd)}, 32,
			{17'd0, sdes_pkg::CMD_LIMIT});
		res.cmd_raw = (rq.vel_cmd[47] ^ scale_cmd[47]) ? -m[31:0] : m[31:0];

		mag_vel = magnitude48({{16{held_vel[31]}}, held_vel});
		m = shift_saturate({48'd0, mag_vel} * {48'd0, magnitude48(scale_fb)}, 24,
			{1'b0, sdes_pkg::FB_LIMIT});
		res.feedback = (held_vel[31] ^ scale_fb[47]) ? -m : m;
		r = shift_saturate({48'd0, mag_vel} * {48'd0, scale_rpm}, 24,
			{1'b0, sdes_pkg::FB_LIMIT});
		res.rpm = held_vel[31] ? -r : r;
		res.rpm_abs = r[46:0];
		return res;
	endfunction

	task automatic write_register(logic [1:0] idx, logic [47:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			sdes_pkg::REG_CMD_GAIN:    scale_cmd = val;
			sdes_pkg::REG_FB_GAIN:     scale_fb = val;
			sdes_pkg::REG_RPM_GAIN:    scale_rpm = val;
			sdes_pkg::REG_FAULT_GRACE: grace_ns = val[30:0];
			default: ;
		endcase
	endtask

	// Offers one request, waits for the handshake, then queues its expected
	// result. Random gaps before the request, while idling is on, put bubbles into the pipeline.
	task automatic send_request(drive_req_t rq, bit pinned, drive_res_t pin);
		drive_res_t                want;
		logic [sdes_pkg::IN_W-1:0] data;

		if (idle_on) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		data = '0;
		data[sdes_pkg::IN_STATUS_LO +: 16] = rq.status;
		data[sdes_pkg::IN_VEL_LO +: 32]    = rq.vel_raw;
		data[sdes_pkg::IN_PERIOD_LO +: 30] = rq.period;
		data[sdes_pkg::IN_ENABLE]          = rq.enable;
		data[sdes_pkg::IN_CMD_LO +: 48]    = rq.vel_cmd;
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= rq.link;
		do @(posedge clk); while (!s_tready);
		want = predict_drive_step(rq);
		if (pinned) begin
			want.flags   = pin.flags;
			want.enabled = pin.enabled;
			want.fault   = pin.fault;
			want.ctrl    = pin.ctrl;
		end
		expected_results.push_back(want);
	endtask

	// Stops offering and waits, within a guard limit, until every queued result
	// has come back, then waits on so the pipeline is empty before registers change.
	task automatic drain_results();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	function automatic logic [47:0] pick_gain(bit signed_gain);
		logic [63:0] wide;
		logic [47:0] g;
		wide = {$urandom, $urandom};
		case ($urandom_range(5))
			0: g = signed_gain ? 48'h7fff_ffff_ffff : 48'hffff_ffff_ffff;
			1: g = signed_gain ? 48'h8000_0000_0000 : 48'h0;
			2: g = wide[47:0];
			default: begin
				// Realistic gains: a 32-bit value placed somewhere in the word.
				g = 48'(wide[31:0]) << $urandom_range(16);
				if (signed_gain && wide[63]) begin
					g = -g;
				end
			end
		endcase
		return g;
	endfunction

	// Receiver: random stalls, no stalls while idling is off, and a long
	// hold-off whenever the stimulus asks for one so the unit backs up.
	always @(posedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			hold_left    <= HOLD_CYCLES;
			m_tready     <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Result checker: every accepted result is compared field by field with
	// the oldest expectation.
	always @(posedge clk) begin : result_check
		drive_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending", 64'(m_tdata[63:0]), 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[OUT_FLAGS_LO +: 7] !== want.flags)
					report_mismatch("status_flags", 64'(m_tdata[OUT_FLAGS_LO +: 7]),
						64'(want.flags));
				if (m_tdata[OUT_ENABLED] !== want.enabled)
					report_mismatch("drive_enabled", 64'(m_tdata[OUT_ENABLED]),
						64'(want.enabled));
				if (m_tdata[OUT_FAULT] !== want.fault)
					report_mismatch("fault_out", 64'(m_tdata[OUT_FAULT]), 64'(want.fault));
				if (m_tdata[OUT_CTRL_LO +: 8] !== want.ctrl)
					report_mismatch("control_word", 64'(m_tdata[OUT_CTRL_LO +: 8]),
						64'(want.ctrl));
				if (m_tdata[OUT_CMD_LO +: 32] !== want.cmd_raw)
					report_mismatch("vel_cmd_raw", 64'(m_tdata[OUT_CMD_LO +: 32]),
						64'(want.cmd_raw));
				if (m_tdata[OUT_FB_LO +: 48] !== want.feedback)
					report_mismatch("vel_feedback", 64'(m_tdata[OUT_FB_LO +: 48]),
						64'(want.feedback));
				if (m_tdata[OUT_RPM_LO +: 48] !== want.rpm)
					report_mismatch("vel_rpm", 64'(m_tdata[OUT_RPM_LO +: 48]), 64'(want.rpm));
				if (m_tdata[OUT_ABS_LO +: 47] !== want.rpm_abs)
					report_mismatch("vel_rpm_abs", 64'(m_tdata[OUT_ABS_LO +: 47]),
						64'(want.rpm_abs));
			end
		end
	end

	initial begin
		drive_req_t  rq;
		drive_res_t  pin;
		logic [63:0] wide;
		logic [47:0] g_cmd;
		logic [47:0] g_fb;
		logic [47:0] g_rpm;
		logic [30:0] g_grace;

		// Register and drive state right after reset.
		scale_cmd     = '0;
		scale_fb      = '0;
		scale_rpm     = '0;
		grace_ns      = sdes_pkg::GRACE_RESET;
		timer_ns      = '0;
		fault_latched = 1'b0;
		held_vel      = '0;
		pin           = '{default: '0};

		// Directed requests. The drive starts with its fault timer at zero, so
		// a fault with enable on the very first request is reported at once; the
		// grace time stays at its reset value of 100 ms for the timing rows.
		directed_rows = '{
			// fault right after reset, then fault reaction active
			'{1'b1, 16'h0008, 32'h7fffffff, 30'd1000000, 1'b1, 48'h7fffffffffff,
				1'b1, 7'h08, 1'b0, 1'b1, sdes_pkg::CW_FAULT_RESET},
			'{1'b1, 16'h000f, 32'h80000000, 30'd1000000, 1'b1, 48'h800000000000,
				1'b1, 7'h0f, 1'b1, 1'b1, sdes_pkg::CW_FAULT_RESET},
			// walk up the state machine: not ready, disabled, ready, on, operating
			'{1'b1, 16'h0000, 32'h00000000, 30'd1000000, 1'b1, 48'h000000000000,
				1'b1, 7'h00, 1'b0, 1'b0, sdes_pkg::CW_NONE},
			'{1'b1, 16'h0040, 32'hffffffff, 30'd1000000, 1'b1, 48'hffffffffffff,
				1'b1, 7'h10, 1'b0, 1'b0, sdes_pkg::CW_SHUTDOWN},
			'{1'b1, 16'h0021, 32'h00010000, 30'd1000000, 1'b1, 48'h000100000000,
				1'b1, 7'h01, 1'b0, 1'b0, sdes_pkg::CW_SWITCH_ON},
			'{1'b1, 16'h0023, 32'hfffe0000, 30'd1000000, 1'b1, 48'hffff00000000,
				1'b1, 7'h03, 1'b0, 1'b0, sdes_pkg::CW_ENABLE_OP},
			'{1'b1, 16'h0027, 32'h00001234, 30'd1000000, 1'b1, 48'h000012340000,
				1'b1, 7'h07, 1'b1, 1'b0, sdes_pkg::CW_ENABLE_OP},
			// every status bit set with enable off reloads the timer
			'{1'b1, 16'hffff, 32'h7fffffff, 30'd1000000, 1'b0, 48'h7fffffffffff,
				1'b1, 7'h7f, 1'b1, 1'b0, sdes_pkg::CW_NONE},
			// fault held through the grace time: two partial periods, then fault
			'{1'b1, 16'h0008, 32'h00000100, 30'd60000000, 1'b1, 48'h000000010000,
				1'b1, 7'h08, 1'b0, 1'b0, sdes_pkg::CW_FAULT_RESET},
			'{1'b1, 16'h0008, 32'h00000100, 30'd60000000, 1'b1, 48'h000000010000,
				1'b1, 7'h08, 1'b0, 1'b0, sdes_pkg::CW_FAULT_RESET},
			'{1'b1, 16'h0008, 32'h00000100, 30'd60000000, 1'b1, 48'h000000010000,
				1'b1, 7'h08, 1'b0, 1'b1, sdes_pkg::CW_FAULT_RESET},
			// link down: fault only, fault output and velocity held
			'{1'b0, 16'h0027, 32'h12345678, 30'd1000000, 1'b1, 48'h000000010000,
				1'b1, sdes_pkg::FLAGS_FAULT_ONLY, 1'b0, 1'b1, sdes_pkg::CW_FAULT_RESET},
			'{1'b0, 16'h0000, 32'h87654321, 30'd1000000, 1'b0, 48'h000000010000,
				1'b1, sdes_pkg::FLAGS_FAULT_ONLY, 1'b0, 1'b1, sdes_pkg::CW_NONE},
			// warning and limit bits alone, or switched on without ready, give no control word
			'{1'b1, 16'h0880, 32'h00000001, 30'd1000000, 1'b1, 48'h000000000001,
				1'b1, 7'h60, 1'b0, 1'b0, sdes_pkg::CW_NONE},
			'{1'b1, 16'h0002, 32'h00000001, 30'd1000000, 1'b1, 48'h000000000001,
				1'b1, 7'h02, 1'b0, 1'b0, sdes_pkg::CW_NONE},
			// fault wins over disabled; longest period drives the timer negative
			'{1'b1, 16'h004f, 32'h00000001, PERIOD_MAX, 1'b1, 48'h000000000001,
				1'b1, 7'h1f, 1'b1, 1'b0, sdes_pkg::CW_FAULT_RESET},
			'{1'b1, 16'h0008, 32'h00000001, 30'd0, 1'b1, 48'h000000000001,
				1'b1, 7'h08, 1'b0, 1'b1, sdes_pkg::CW_FAULT_RESET},
			'{1'b1, 16'h0008, 32'h00000001, 30'd0, 1'b0, 48'h000000000001,
				1'b1, 7'h08, 1'b0, 1'b0, sdes_pkg::CW_NONE},
			// velocity extremes, predicted only
			'{1'b1, 16'h0027, 32'h80000000, 30'd5000000, 1'b1, 48'h800000000000,
				1'b0, 7'h00, 1'b0, 1'b0, sdes_pkg::CW_NONE},
			'{1'b0, 16'h0027, 32'h7fffffff, 30'd5000000, 1'b1, 48'h000000010000,
				1'b0, 7'h00, 1'b0, 1'b0, sdes_pkg::CW_NONE},
			'{1'b1, 16'h0040, 32'h00000001, 30'd5000000, 1'b1, 48'hffffffffffff,
				1'b0, 7'h00, 1'b0, 1'b0, sdes_pkg::CW_NONE}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Largest positive gains for the directed part; the grace time is left
		// at its reset value.
		write_register(sdes_pkg::REG_CMD_GAIN, 48'h7fff_ffff_ffff);
		write_register(sdes_pkg::REG_FB_GAIN, 48'h7fff_ffff_ffff);
		write_register(sdes_pkg::REG_RPM_GAIN, 48'hffff_ffff_ffff);
		cfg_we <= 1'b0;

		foreach (directed_rows[i]) begin
			rq.link    = directed_rows[i].link;
			rq.status  = directed_rows[i].status;
			rq.vel_raw = directed_rows[i].vel_raw;
			rq.period  = directed_rows[i].period;
			rq.enable  = directed_rows[i].enable;
			rq.vel_cmd = directed_rows[i].vel_cmd;
			pin.flags   = directed_rows[i].flags;
			pin.enabled = directed_rows[i].enabled;
			pin.fault   = directed_rows[i].fault;
			pin.ctrl    = directed_rows[i].ctrl;
			send_request(rq, directed_rows[i].pinned, pin);
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain_results();

			// Fixed extremes in the first phases, random settings afterwards.
			case (phase)
				0: begin
					g_cmd = 48'h7fff_ffff_ffff;
					g_fb = 48'h7fff_ffff_ffff;
					g_rpm = 48'hffff_ffff_ffff;
					g_grace = 31'h7fffffff;
				end
				1: begin
					g_cmd = 48'h8000_0000_0000;
					g_fb = 48'h8000_0000_0000;
					g_rpm = 48'h0;
					g_grace = 31'd0;
				end
				2: begin
					g_cmd = 48'hffff_ffff_ffff;
					g_fb = 48'h0000_0000_0001;
					g_rpm = 48'h0000_0100_0000;
					g_grace = 31'd1;
				end
				default: begin
					g_cmd = pick_gain(1'b1);
					g_fb = pick_gain(1'b1);
					g_rpm = pick_gain(1'b0);
					case ($urandom_range(4))
						0: g_grace = 31'd0;
						1: g_grace = 31'h7fffffff;
						default: g_grace = 31'($urandom_range(300000000, 1));
					endcase
				end
			endcase
			write_register(sdes_pkg::REG_CMD_GAIN, g_cmd);
			write_register(sdes_pkg::REG_FB_GAIN, g_fb);
			write_register(sdes_pkg::REG_RPM_GAIN, g_rpm);
			write_register(sdes_pkg::REG_FAULT_GRACE, {17'd0, g_grace});
			cfg_we <= 1'b0;

			// Two phases run without any idling; the first of them also holds
			// the receiver off for a long stretch while requests keep coming.
			idle_on = !(phase == 4 || phase == 5);
			if (phase == 4) begin
				holds_asked++;
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < NOISE_PERCENT) begin
					// Noise: any status word, link and enable at random.
					rq.link   = 1'($urandom);
					rq.status = 16'($urandom);
					rq.enable = 1'($urandom);
					rq.period = 30'($urandom_range(PERIOD_MAX));
				end else begin
					// Well-formed: a drive that climbs to operation enabled,
					// drops into fault episodes of random length and restarts.
					rq.link   = ($urandom_range(99) < 93);
					rq.enable = ($urandom_range(99) < 90);
					if (fault_left != 0) begin
						fault_left--;
						if (fault_left == 0) begin
							drv_phase = DRV_DISABLED;
						end
					end else if ($urandom_range(99) < 4) begin
						fault_left = $urandom_range(14, 1);
					end else if ($urandom_range(99) < 40) begin
						case (drv_phase)
							DRV_DISABLED:    drv_phase = DRV_READY;
							DRV_READY:       drv_phase = DRV_SWITCHED_ON;
							default:         drv_phase = DRV_OPERATION;
						endcase
					end
					if (fault_left != 0) begin
						rq.status = $urandom_range(1) ? SW_FAULT_ACTIVE : SW_FAULT;
					end else begin
						case (drv_phase)
							DRV_DISABLED:    rq.status = SW_DISABLED;
							DRV_READY:       rq.status = SW_READY;
							DRV_SWITCHED_ON: rq.status = SW_SWITCHED_ON;
							default:         rq.status = SW_OPERATION;
						endcase
					end
					if ($urandom_range(99) < 20) begin
						rq.status |= 16'($urandom) & ~SW_USED_BITS;
					end
					if ($urandom_range(99) < 10) begin
						rq.status |= 16'($urandom) & SW_WARN_LIMIT;
					end
					case ($urandom_range(19))
						0: rq.period = 30'd0;
						1: rq.period = PERIOD_MAX;
						default: rq.period = 30'($urandom_range(40000000, 200000));
					endcase
				end

				wide = {$urandom, $urandom};
				case ($urandom_range(9))
					0: rq.vel_raw = 32'h7fffffff;
					1: rq.vel_raw = 32'h80000000;
					2, 3: rq.vel_raw = wide[31:0];
					default: begin
						rq.vel_raw = $urandom_range(32'h00400000);
						if (wide[63]) begin
							rq.vel_raw = -rq.vel_raw;
						end
					end
				endcase
				wide = {$urandom, $urandom};
				case ($urandom_range(9))
					0: rq.vel_cmd = 48'h7fff_ffff_ffff;
					1: rq.vel_cmd = 48'h8000_0000_0000;
					2, 3: rq.vel_cmd = wide[47:0];
					default: begin
						rq.vel_cmd = 48'($urandom_range(32'h01000000)) << $urandom_range(16);
						if (wide[63]) begin
							rq.vel_cmd = -rq.vel_cmd;
						end
					end
				endcase
				send_request(rq, 1'b0, pin);
			end
		end

		drain_results();
		if (expected_results.size() != 0) begin
			report_mismatch("results never delivered", 64'(expected_results.size()), 64'd0);
		end
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/sdes_pkg.sv
hw/rtl/sdes_state_ctrl.sv
hw/rtl/servo_drive_enable_sequencer_unit.sv
sim/tb_top.sv
